FILE: design/hdfd_pkg.sv
// hdfd_pkg: shared constants, codes and types for the header delimited frame decoder
// no dependencies; imported by every design module and the checker
`default_nettype none

package hdfd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 128;
  localparam int unsigned HEAD_DEPTH    = 15;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = 121;
  localparam int unsigned OUT_TDATA_W = 128;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_RC     = 8'h01;
  localparam logic [7:0] TYPE_LINK   = 8'h04;
  localparam logic [7:0] TYPE_MODE   = 8'h85;
  localparam logic [7:0] LINK_LOST   = 8'h03;
  localparam logic [7:0] LEN_OVERHEAD = 8'd4;

  // failsafe register reset values, entry i is channel i
  localparam logic [3:0][15:0] FS_RST = {16'd1500, 16'd1400, 16'd1500, 16'd1500};

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_LEN_ERR  = 2'd1,
    STAT_CSUM_ERR = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FS_CH0 = 2'd0,
    CFG_FS_CH1 = 2'd1,
    CFG_FS_CH2 = 2'd2,
    CFG_FS_CH3 = 2'd3
  } cfg_idx_e;

  // frame close event; head[k-1] is frame byte k
  typedef struct packed {
    logic                           fire;
    status_e                        status;
    logic [HEAD_DEPTH-1:0][7:0]     head;
  } close_t;

  typedef struct packed {
    logic [3:0][15:0] ch;
    logic [7:0]       ch4;
    logic [5:0]       keys;
    logic [7:0]       link;
    logic             failsafe;
    logic [7:0]       mode;
    logic [15:0]      errors;
  } held_t;

endpackage

`default_nettype wire

FILE: design/hdfd_frame_track.sv
// hdfd_frame_track: frame position, running xor and captured head bytes
// uses hdfd_pkg; flags the frame close and its status from the current byte
`default_nettype none

module hdfd_frame_track
  import hdfd_pkg::*;
#(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] byte_i,
  input  wire logic       take_i,
  output close_t          close_o
);

  localparam int unsigned PosW = $clog2(MaxFrame + 1);

  logic                       in_frame_q, in_frame_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [7:0]                 xor_q, xor_d;
  logic [7:0]                 last_q, last_d;
  logic [HEAD_DEPTH-1:0][7:0] head_q, head_d;

  logic       is_hdr;
  logic       too_long;
  logic [7:0] n8;

  assign is_hdr   = (byte_i == HEADER_BYTE);
  assign too_long = (pos_q >= PosW'(MaxFrame));
  assign n8       = 8'(pos_q);

  always_comb begin
    close_o.fire = in_frame_q && (is_hdr || too_long);
    close_o.head = head_q;
    if (!is_hdr) begin
      close_o.status = STAT_TOO_LONG;
    end else if ((n8 < LEN_OVERHEAD) || (head_q[0] != (n8 - LEN_OVERHEAD))) begin
      close_o.status = STAT_LEN_ERR;
    end else if (xor_q != last_q) begin
      close_o.status = STAT_CSUM_ERR;
    end else begin
      close_o.status = STAT_OK;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    xor_d      = xor_q;
    last_d     = last_q;
    head_d     = head_q;
    if (take_i) begin
      if (is_hdr) begin
        // header opens a frame, also right after closing one
        in_frame_d = 1'b1;
        pos_d      = PosW'(1);
        xor_d      = '0;
        last_d     = '0;
        head_d     = '0;
      end else if (in_frame_q) begin
        if (too_long) begin
          in_frame_d = 1'b0;
        end else begin
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            if (pos_q == PosW'(i + 1)) head_d[i] = byte_i;
          end
          xor_d  = xor_q ^ byte_i;
          last_d = byte_i;
          pos_d  = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      xor_q      <= '0;
      last_q     <= '0;
      head_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      xor_q      <= xor_d;
      last_q     <= last_d;
      head_q     <= head_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/hdfd_held_regs.sv
// hdfd_held_regs: held channel, link, mode and error values plus failsafe registers
// uses hdfd_pkg; updated from the close event of hdfd_frame_track
`default_nettype none

module hdfd_held_regs
  import hdfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire close_t      close_i,
  input  wire logic        take_i,
  output held_t            held_o
);

  logic [3:0][15:0] fs_q;
  held_t            held_q, held_d;

  always_comb begin
    held_d = held_q;
    if (take_i && close_i.fire) begin
      case (close_i.status)
        STAT_OK: begin
          case (close_i.head[2])
            TYPE_RC: begin
              for (int i = 0; i < 4; i++) begin
                held_d.ch[i] = {close_i.head[4 + 2 * i], close_i.head[3 + 2 * i]};
              end
              held_d.ch4  = close_i.head[11];
              held_d.keys = close_i.head[14][6:1];
            end
            TYPE_LINK: begin
              held_d.link = close_i.head[3];
              if (close_i.head[3] == LINK_LOST) begin
                held_d.ch       = fs_q;
                held_d.keys     = '0;
                held_d.failsafe = 1'b1;
              end
            end
            TYPE_MODE: held_d.mode = close_i.head[3];
            default: ;
          endcase
        end
        STAT_CSUM_ERR: held_d.errors = held_q.errors + 16'd1;
        default: ;
      endcase
    end
  end

  assign held_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_FS_CH0: fs_q[0] <= cfg_wdata_i;
        CFG_FS_CH1: fs_q[1] <= cfg_wdata_i;
        CFG_FS_CH2: fs_q[2] <= cfg_wdata_i;
        CFG_FS_CH3: fs_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/header_delimited_frame_decoder_top.sv
// path: a byte accepted into the input register is decoded from there; a closing transaction
//   is written to the result register, which drives the master side
// throughput: one byte per cycle, set by the single decode stage between the input
//   register and the result register; a byte that closes a frame waits while a held result is not drained
// reset: rst_ni clears frame tracking and held values, failsafe registers go to 1500/1500/1400/1500
// top level of the header delimited frame decoder; uses hdfd_pkg, hdfd_frame_track,
// hdfd_held_regs
`default_nettype none

module header_delimited_frame_decoder_top
  import hdfd_pkg::*;
#(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // slave side: tdata = rx_byte[7:0]
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // master side: tdata = status[1:0], channel0[17:2], channel1[33:18], channel2[49:34],
  // channel3[65:50], channel4[73:66], keys[79:74], link_state[87:80], failsafe[88],
  // operate_mode[96:89], error_count[112:97], frame_type[120:113], zeros[127:121]
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // configuration write port, index 0..3 = failsafe channel 0..3
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_addr_i,
  input  wire logic [15:0]            cfg_wdata_i
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;

  // result register
  logic       out_valid_q, out_valid_d;
  status_e    out_status_q, out_status_d;
  held_t      out_held_q, out_held_d;
  logic [7:0] out_type_q, out_type_d;

  close_t close;
  held_t  held_next;
  logic   out_free;
  logic   take;

  // result slot free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  // a byte that closes a frame needs the result slot, others always go
  assign take     = in_valid_q && (!close.fire || out_free);

  assign s_axis_tready_o = !in_valid_q || take;

  hdfd_frame_track #(
    .MaxFrame (MaxFrame)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (in_byte_q),
    .take_i  (take),
    .close_o (close)
  );

  hdfd_held_regs u_held (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .close_i     (close),
    .take_i      (take),
    .held_o      (held_next)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_byte_d  = s_axis_tdata_i;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_held_d   = out_held_q;
    out_type_d   = out_type_q;
    if (take && close.fire) begin
      // every result carries the held values after this frame's update
      out_valid_d  = 1'b1;
      out_status_d = close.status;
      out_held_d   = held_next;
      out_type_d   = close.head[2];
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_byte_q    <= in_byte_d;
    out_status_q <= out_status_d;
    out_held_q   <= out_held_d;
    out_type_q   <= out_type_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                            out_type_q,
                            out_held_q.errors,
                            out_held_q.mode,
                            out_held_q.failsafe,
                            out_held_q.link,
                            out_held_q.keys,
                            out_held_q.ch4,
                            out_held_q.ch[3],
                            out_held_q.ch[2],
                            out_held_q.ch[1],
                            out_held_q.ch[0],
                            out_status_q};

endmodule

`default_nettype wire

FILE: design/hdfd_checker.sv
// hdfd_checker: port level checks for the header delimited frame decoder
// uses hdfd_pkg; bound to header_delimited_frame_decoder_top
`default_nettype none

module hdfd_checker
  import hdfd_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // pad bits above the fields stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_TDATA_W-1:OUT_FIELD_W] == '0))
    else $error("tdata pad bits not zero");

  // failsafe flag is sticky once reported
  a_failsafe_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[88] |=> !m_axis_tvalid_o || m_axis_tdata_o[88])
    else $error("failsafe flag cleared");

  // a fresh result follows an input byte taken into the input register
  a_rise_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result without a preceding input transaction");

endmodule

bind header_delimited_frame_decoder_top hdfd_checker u_hdfd_checker (.*);

`default_nettype wire
